>>> hdl/vtsm_pkg.sv
// ----------------------------------------------------------------------------
// vtsm_pkg
// Shared types and constants of the voxel splat max-blend unit.
// ----------------------------------------------------------------------------
package vtsm_pkg;

  localparam int PosW      = 14;
  localparam int ColW      = 8;
  localparam int CoordInW  = 3;
  localparam int KindW     = 2;
  localparam int VoxelW    = 3 * ColW;

  localparam int VoxelsPerSideDef = 8;
  localparam int FracBitsDef      = 8;

  typedef enum logic [KindW-1:0] {
    KIND_CLEAR = 2'd0,
    KIND_SPLAT = 2'd1,
    KIND_READ  = 2'd2,
    KIND_NOP   = 2'd3
  } kind_e;

endpackage

>>> hdl/vtsm_if.sv
// ----------------------------------------------------------------------------
// vtsm request and response channels
// Valid/ready channels that carry a request item and a read result.
// ----------------------------------------------------------------------------
interface vtsm_req_if;
  logic                                 valid;
  logic                                 ready;
  vtsm_pkg::kind_e                      kind;
  logic signed [vtsm_pkg::PosW-1:0]     pos_x;
  logic signed [vtsm_pkg::PosW-1:0]     pos_y;
  logic signed [vtsm_pkg::PosW-1:0]     pos_z;
  logic [vtsm_pkg::ColW-1:0]            red_in;
  logic [vtsm_pkg::ColW-1:0]            green_in;
  logic [vtsm_pkg::ColW-1:0]            blue_in;
  logic [vtsm_pkg::CoordInW-1:0]        read_x;
  logic [vtsm_pkg::CoordInW-1:0]        read_y;
  logic [vtsm_pkg::CoordInW-1:0]        read_z;

  modport source (
    output valid, kind, pos_x, pos_y, pos_z, red_in, green_in, blue_in,
           read_x, read_y, read_z,
    input  ready
  );
  modport sink (
    input  valid, kind, pos_x, pos_y, pos_z, red_in, green_in, blue_in,
           read_x, read_y, read_z,
    output ready
  );
endinterface

interface vtsm_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [vtsm_pkg::ColW-1:0] red_out;
  logic [vtsm_pkg::ColW-1:0] green_out;
  logic [vtsm_pkg::ColW-1:0] blue_out;

  modport source (
    output valid, red_out, green_out, blue_out,
    input  ready
  );
  modport sink (
    input  valid, red_out, green_out, blue_out,
    output ready
  );
endinterface

>>> hdl/voxel_trilinear_splat_max_unit.sv
// ----------------------------------------------------------------------------
// voxel_trilinear_splat_max_unit
// RGB voxel cube with clear, trilinear max-blend splat and voxel read.
// ----------------------------------------------------------------------------
// The unit takes one request at a time and drops ready until it is done.
// A clear writes zero to one voxel per cycle, VoxelsPerSide^3 voxels
// (512 at the default size); the same pass runs right after reset, and no
// request is taken until it ends. A splat visits its eight neighbors in
// turn on one multiplier and one store port: a neighbor outside the cube
// is skipped, one whose weight is at most 0.02 is dropped once its weight
// is formed, and one that is blended takes two weight products, three
// channel products and one read-modify-write.
// A read passes the states ST_RD and ST_RDW and then waits only while an
// earlier result still sits in the output register.
module voxel_trilinear_splat_max_unit #(
  parameter int VoxelsPerSide = vtsm_pkg::VoxelsPerSideDef,
  parameter int FracBits      = vtsm_pkg::FracBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  vtsm_req_if.sink    req_i,
  vtsm_rsp_if.source  rsp_o
);

  localparam int Cells  = VoxelsPerSide * VoxelsPerSide * VoxelsPerSide;
  localparam int AddrW  = $clog2(Cells);
  localparam int CW     = $clog2(VoxelsPerSide);
  localparam int CellW  = vtsm_pkg::PosW - FracBits;
  localparam int NcW    = CellW + 1;
  localparam int WtW    = FracBits + 1;
  localparam int MulAW  = 3 * FracBits + 1;
  localparam int MulBW  = (FracBits + 1 > vtsm_pkg::ColW) ? FracBits + 1 : vtsm_pkg::ColW;
  localparam int ProdW  = MulAW + MulBW;
  localparam int ThrW   = 3 * FracBits + 7;
  localparam int RndW   = 3 * FracBits + 8;
  localparam int Scale  = 1 << FracBits;
  localparam int ColW   = vtsm_pkg::ColW;
  localparam int VoxW   = vtsm_pkg::VoxelW;

  localparam logic [ThrW-1:0] Full = ThrW'(1) << (3 * FracBits);
  localparam logic [RndW-1:0] Half = RndW'(1) << (3 * FracBits - 1);

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_RD,
    ST_RDW,
    ST_NB,
    ST_WZ,
    ST_THR,
    ST_CR,
    ST_CG,
    ST_CB
  } state_e;

  state_e                    state_q;
  logic [AddrW-1:0]          cnt_q;
  logic [2:0]                nb_q;
  logic signed [CellW-1:0]   base_x_q, base_y_q, base_z_q;
  logic [FracBits-1:0]       frac_x_q, frac_y_q, frac_z_q;
  logic [ColW-1:0]           red_q, green_q, blue_q;
  logic [vtsm_pkg::CoordInW-1:0] rx_q, ry_q, rz_q;
  logic [ProdW-1:0]          mul_q;
  logic [MulAW-1:0]          w_q;
  logic [ColW-1:0]           vr_q, vg_q;
  logic                      out_valid_q;
  logic [ColW-1:0]           out_r_q, out_g_q, out_b_q;

  logic [VoxW-1:0]           mem_q [Cells];
  logic [VoxW-1:0]           rdata_q;

  logic [MulAW-1:0]          mul_a;
  logic [MulBW-1:0]          mul_b;
  logic signed [NcW-1:0]     cx, cy, cz;
  logic                      nb_in;
  logic [WtW-1:0]            wx, wy, wz;
  logic [AddrW-1:0]          nb_addr, rd_addr, mem_raddr, mem_waddr;
  logic                      rd_oor;
  logic                      mem_we;
  logic [VoxW-1:0]           mem_wdata;
  logic [RndW-1:0]           rnd;
  logic [ColW-1:0]           v_round;
  logic [ColW-1:0]           max_r, max_g, max_b;

  function automatic logic [AddrW-1:0] cell_addr(logic [CW-1:0] x, logic [CW-1:0] y,
                                                 logic [CW-1:0] z);
    return AddrW'(x) + AddrW'(y) * AddrW'(VoxelsPerSide)
         + AddrW'(z) * AddrW'(VoxelsPerSide * VoxelsPerSide);
  endfunction

  function automatic logic over_thr(logic [ThrW-1:0] w);
    logic [ThrW-1:0] t;
    t = (w << 5) + (w << 4) + (w << 1);
    return t > Full;
  endfunction

  assign req_i.ready     = (state_q == ST_IDLE);
  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.red_out   = out_r_q;
  assign rsp_o.green_out = out_g_q;
  assign rsp_o.blue_out  = out_b_q;

  assign cx = NcW'(base_x_q) + NcW'({1'b0, nb_q[0]});
  assign cy = NcW'(base_y_q) + NcW'({1'b0, nb_q[1]});
  assign cz = NcW'(base_z_q) + NcW'({1'b0, nb_q[2]});
  assign nb_in = (int'(cx) >= 0) && (int'(cx) < VoxelsPerSide)
              && (int'(cy) >= 0) && (int'(cy) < VoxelsPerSide)
              && (int'(cz) >= 0) && (int'(cz) < VoxelsPerSide);
  assign nb_addr = cell_addr(CW'(cx), CW'(cy), CW'(cz));

  assign wx = nb_q[0] ? WtW'(frac_x_q) : WtW'(Scale) - WtW'(frac_x_q);
  assign wy = nb_q[1] ? WtW'(frac_y_q) : WtW'(Scale) - WtW'(frac_y_q);
  assign wz = nb_q[2] ? WtW'(frac_z_q) : WtW'(Scale) - WtW'(frac_z_q);

  assign rd_oor = (32'(rx_q) >= VoxelsPerSide) || (32'(ry_q) >= VoxelsPerSide)
               || (32'(rz_q) >= VoxelsPerSide);
  assign rd_addr = cell_addr(CW'(rx_q), CW'(ry_q), CW'(rz_q));

  assign rnd     = RndW'(mul_q) + Half;
  assign v_round = rnd[RndW-1 -: ColW];

  assign max_r = (vr_q    > rdata_q[VoxW-1 -: ColW])   ? vr_q    : rdata_q[VoxW-1 -: ColW];
  assign max_g = (vg_q    > rdata_q[2*ColW-1 -: ColW]) ? vg_q    : rdata_q[2*ColW-1 -: ColW];
  assign max_b = (v_round > rdata_q[ColW-1:0])         ? v_round : rdata_q[ColW-1:0];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_NB: begin
        mul_a = MulAW'(wx);
        mul_b = MulBW'(wy);
      end
      ST_WZ: begin
        mul_a = mul_q[MulAW-1:0];
        mul_b = MulBW'(wz);
      end
      ST_THR: begin
        mul_a = mul_q[MulAW-1:0];
        mul_b = MulBW'(red_q);
      end
      ST_CR: begin
        mul_a = w_q;
        mul_b = MulBW'(green_q);
      end
      ST_CG: begin
        mul_a = w_q;
        mul_b = MulBW'(blue_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt_q;
    mem_wdata = '0;
    mem_raddr = nb_addr;
    case (state_q)
      ST_CLR: begin
        mem_we = 1'b1;
      end
      ST_CB: begin
        mem_we    = 1'b1;
        mem_waddr = nb_addr;
        mem_wdata = {max_r, max_g, max_b};
      end
      ST_RD, ST_RDW: begin
        mem_raddr = rd_addr;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_raddr];
  end

  always_ff @(posedge clk_i) begin
    mul_q <= ProdW'(mul_a) * ProdW'(mul_b);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      cnt_q       <= '0;
      nb_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == ST_RDW && (!out_valid_q || rsp_o.ready)) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLR: begin
          if (cnt_q == AddrW'(Cells - 1)) begin
            cnt_q   <= '0;
            state_q <= ST_IDLE;
          end else begin
            cnt_q <= cnt_q + AddrW'(1);
          end
        end
        ST_IDLE: begin
          if (req_i.valid) begin
            base_x_q <= req_i.pos_x[vtsm_pkg::PosW-1:FracBits];
            base_y_q <= req_i.pos_y[vtsm_pkg::PosW-1:FracBits];
            base_z_q <= req_i.pos_z[vtsm_pkg::PosW-1:FracBits];
            frac_x_q <= req_i.pos_x[FracBits-1:0];
            frac_y_q <= req_i.pos_y[FracBits-1:0];
            frac_z_q <= req_i.pos_z[FracBits-1:0];
            red_q    <= req_i.red_in;
            green_q  <= req_i.green_in;
            blue_q   <= req_i.blue_in;
            rx_q     <= req_i.read_x;
            ry_q     <= req_i.read_y;
            rz_q     <= req_i.read_z;
            nb_q     <= '0;
            case (req_i.kind)
              vtsm_pkg::KIND_CLEAR: state_q <= ST_CLR;
              vtsm_pkg::KIND_SPLAT: state_q <= ST_NB;
              vtsm_pkg::KIND_READ:  state_q <= ST_RD;
              default:              state_q <= ST_IDLE;
            endcase
          end
        end
        ST_RD: begin
          state_q <= ST_RDW;
        end
        ST_RDW: begin
          if (!out_valid_q || rsp_o.ready) begin
            out_r_q     <= rd_oor ? '0 : rdata_q[VoxW-1 -: ColW];
            out_g_q     <= rd_oor ? '0 : rdata_q[2*ColW-1 -: ColW];
            out_b_q     <= rd_oor ? '0 : rdata_q[ColW-1:0];
            state_q     <= ST_IDLE;
          end
        end
        ST_NB: begin
          if (nb_in) begin
            state_q <= ST_WZ;
          end else begin
            nb_q    <= nb_q + 3'd1;
            state_q <= (nb_q == 3'd7) ? ST_IDLE : ST_NB;
          end
        end
        ST_WZ: begin
          state_q <= ST_THR;
        end
        ST_THR: begin
          w_q <= mul_q[MulAW-1:0];
          if (over_thr(ThrW'(mul_q))) begin
            state_q <= ST_CR;
          end else begin
            nb_q    <= nb_q + 3'd1;
            state_q <= (nb_q == 3'd7) ? ST_IDLE : ST_NB;
          end
        end
        ST_CR: begin
          vr_q    <= v_round;
          state_q <= ST_CG;
        end
        ST_CG: begin
          vg_q    <= v_round;
          state_q <= ST_CB;
        end
        ST_CB: begin
          nb_q    <= nb_q + 3'd1;
          state_q <= (nb_q == 3'd7) ? ST_IDLE : ST_NB;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  a_no_write_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> !req_i.ready)
    else $error("store written while a request can be accepted");

  a_result_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_RDW))
    else $error("result raised outside a read");

  a_blend_above_thr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CB) |-> over_thr(ThrW'(w_q)))
    else $error("voxel blended with a weight at or below the threshold");

  a_blend_in_cube: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WZ) |-> $past(nb_in) && $stable(nb_q))
    else $error("neighbor outside the cube entered the blend");

endmodule

>>> tb/voxel_trilinear_splat_max_unit_tb.sv
// ----------------------------------------------------------------------------
// voxel_trilinear_splat_max_unit_tb
// Drives clear, splat, read and no-op requests into the voxel splat unit and
// keeps its own copy of the RGB voxel cube. Each accepted splat updates that
// copy with the trilinear max blend; each accepted read queues the color the
// unit must return. A directed pass covers points on voxel corners, points
// outside the cube, weights around the 0.02 cutoff and extreme colors. It is
// followed by random traffic under four pacing phases on both channels.
// ----------------------------------------------------------------------------
module voxel_trilinear_splat_max_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vtsm_pkg::*;

  localparam int     Side       = VoxelsPerSideDef;
  localparam int     FracBits   = FracBitsDef;
  localparam int     Scale      = 1 << FracBits;
  localparam int     CellCount  = Side * Side * Side;
  localparam longint FullWeight = longint'(1) << (3 * FracBits);
  localparam longint HalfWeight = FullWeight >> 1;
  localparam int     CycleLimit = 1000000;
  localparam int     SettleCycles = 600;
  localparam int     MaxPrinted = 40;

  typedef struct {
    kind_e                    kind;
    logic signed [PosW-1:0]   pos_x;
    logic signed [PosW-1:0]   pos_y;
    logic signed [PosW-1:0]   pos_z;
    logic [ColW-1:0]          red;
    logic [ColW-1:0]          green;
    logic [ColW-1:0]          blue;
    logic [CoordInW-1:0]      rd_x;
    logic [CoordInW-1:0]      rd_y;
    logic [CoordInW-1:0]      rd_z;
  } voxel_req_t;

  typedef struct packed {
    logic [ColW-1:0] red;
    logic [ColW-1:0] green;
    logic [ColW-1:0] blue;
  } voxel_rgb_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  vtsm_req_if req_if ();
  vtsm_rsp_if rsp_if ();

  voxel_trilinear_splat_max_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source)
  );

  logic [ColW-1:0] voxel_mem [CellCount][3];
  voxel_rgb_t      read_colors_q [$];

  int src_idle_pct;
  int snk_stall_pct;
  int error_count;
  int cycle_count;
  int n_clear;
  int n_splat;
  int n_read;
  int n_nop;
  int n_checked;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d reads pending", cycle_count,
               read_colors_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic report_mismatch(input string field, input int got, input int want);
    if (error_count < MaxPrinted)
      $display("MISMATCH %s: got %0d, expected %0d (cycle %0d)", field, got, want,
               cycle_count);
    error_count++;
  endtask

  function automatic void clear_store();
    foreach (voxel_mem[i, ch]) voxel_mem[i][ch] = '0;
  endfunction

  function automatic void splat_into_store(input voxel_req_t r);
    int              pv [3];
    int              base [3];
    int              frac [3];
    int              cx, cy, cz, idx;
    longint          w, v;
    logic [ColW-1:0] col [3];
    pv[0] = int'(r.pos_x);
    pv[1] = int'(r.pos_y);
    pv[2] = int'(r.pos_z);
    col[0] = r.red;
    col[1] = r.green;
    col[2] = r.blue;
    for (int a = 0; a < 3; a++) begin
      base[a] = pv[a] >>> FracBits;
      frac[a] = pv[a] & (Scale - 1);
    end
    for (int dz = 0; dz < 2; dz++) begin
      cz = base[2] + dz;
      if (cz < 0 || cz >= Side) continue;
      for (int dy = 0; dy < 2; dy++) begin
        cy = base[1] + dy;
        if (cy < 0 || cy >= Side) continue;
        for (int dx = 0; dx < 2; dx++) begin
          cx = base[0] + dx;
          if (cx < 0 || cx >= Side) continue;
          w = longint'(dx ? frac[0] : Scale - frac[0]) *
              longint'(dy ? frac[1] : Scale - frac[1]) *
              longint'(dz ? frac[2] : Scale - frac[2]);
          if (w * 50 <= FullWeight) continue;
          idx = cx + Side * (cy + Side * cz);
          for (int ch = 0; ch < 3; ch++) begin
            v = (longint'(col[ch]) * w + HalfWeight) >> (3 * FracBits);
            if (v > 255) v = 255;
            if (v > longint'(voxel_mem[idx][ch])) voxel_mem[idx][ch] = v[ColW-1:0];
          end
        end
      end
    end
  endfunction

  function automatic void predict_request(input voxel_req_t r);
    voxel_rgb_t c;
    int         idx;
    case (r.kind)
      KIND_CLEAR: begin
        clear_store();
        n_clear++;
      end
      KIND_SPLAT: begin
        splat_into_store(r);
        n_splat++;
      end
      KIND_READ: begin
        c = '0;
        if (r.rd_x < Side && r.rd_y < Side && r.rd_z < Side) begin
          idx = r.rd_x + Side * (r.rd_y + Side * r.rd_z);
          c.red   = voxel_mem[idx][0];
          c.green = voxel_mem[idx][1];
          c.blue  = voxel_mem[idx][2];
        end
        read_colors_q.push_back(c);
        n_read++;
      end
      default: n_nop++;
    endcase
  endfunction

  task automatic send_request(input voxel_req_t r);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.kind     <= r.kind;
    req_if.pos_x    <= r.pos_x;
    req_if.pos_y    <= r.pos_y;
    req_if.pos_z    <= r.pos_z;
    req_if.red_in   <= r.red;
    req_if.green_in <= r.green;
    req_if.blue_in  <= r.blue;
    req_if.read_x   <= r.rd_x;
    req_if.read_y   <= r.rd_y;
    req_if.read_z   <= r.rd_z;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    predict_request(r);
  endtask

  task automatic wait_reads_drained();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (read_colors_q.size() != 0) @(posedge clk_i);
  endtask

  always @(negedge clk_i) rsp_if.ready <= ($urandom_range(99) >= snk_stall_pct);

  always @(posedge clk_i) begin
    voxel_rgb_t want;
    if (rst_ni === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (read_colors_q.size() == 0) begin
        report_mismatch("result with no read pending, red", rsp_if.red_out, 0);
      end else begin
        want = read_colors_q.pop_front();
        if (rsp_if.red_out !== want.red)
          report_mismatch("red_out", rsp_if.red_out, want.red);
        if (rsp_if.green_out !== want.green)
          report_mismatch("green_out", rsp_if.green_out, want.green);
        if (rsp_if.blue_out !== want.blue)
          report_mismatch("blue_out", rsp_if.blue_out, want.blue);
        n_checked++;
      end
    end
  end

  function automatic voxel_req_t make_req(input kind_e k, input int px, input int py,
                                          input int pz, input int cr, input int cg,
                                          input int cb, input int rx, input int ry,
                                          input int rz);
    voxel_req_t r;
    r.kind  = k;
    r.pos_x = px[PosW-1:0];
    r.pos_y = py[PosW-1:0];
    r.pos_z = pz[PosW-1:0];
    r.red   = cr[ColW-1:0];
    r.green = cg[ColW-1:0];
    r.blue  = cb[ColW-1:0];
    r.rd_x  = rx[CoordInW-1:0];
    r.rd_y  = ry[CoordInW-1:0];
    r.rd_z  = rz[CoordInW-1:0];
    return r;
  endfunction

  function automatic int rand_pos();
    int p;
    if ($urandom_range(99) < 15) return int'($signed(PosW'($urandom)));
    p = int'($urandom_range(Side * Scale + 2 * Scale - 1)) - Scale;
    if ($urandom_range(99) < 20) p = p & ~(Scale - 1);
    return p;
  endfunction

  function automatic int rand_colour();
    if ($urandom_range(99) < 10) return $urandom_range(1) ? 255 : 0;
    return $urandom_range(255);
  endfunction

  function automatic voxel_req_t rand_request();
    int    pick;
    kind_e k;
    pick = $urandom_range(999);
    if (pick < 8)        k = KIND_CLEAR;
    else if (pick < 40)  k = KIND_NOP;
    else if (pick < 430) k = KIND_READ;
    else                 k = KIND_SPLAT;
    return make_req(k, rand_pos(), rand_pos(), rand_pos(), rand_colour(),
                    rand_colour(), rand_colour(), $urandom_range(7),
                    $urandom_range(7), $urandom_range(7));
  endfunction

  task automatic run_random_phase(input int count, input int src_pct, input int snk_pct);
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    for (int i = 0; i < count; i++) send_request(rand_request());
    wait_reads_drained();
  endtask

  task automatic test_directed();
    int half;
    half = Scale / 2;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    send_request(make_req(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_req(KIND_SPLAT, 0, 0, 0, 255, 255, 255, 0, 0, 0));
    send_request(make_req(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_req(KIND_READ, 0, 0, 0, 0, 0, 0, 1, 0, 0));
    send_request(make_req(KIND_SPLAT, -8192, -8192, -8192, 255, 255, 255, 7, 7, 7));
    send_request(make_req(KIND_SPLAT, 8191, 8191, 8191, 255, 255, 255, 7, 7, 7));
    send_request(make_req(KIND_SPLAT, 7 * Scale + half, 7 * Scale + half,
                          7 * Scale + half, 255, 1, 128, 0, 0, 0));
    send_request(make_req(KIND_READ, 0, 0, 0, 0, 0, 0, 7, 7, 7));
    send_request(make_req(KIND_SPLAT, -half, -half, -half, 200, 255, 9, 0, 0, 0));
    send_request(make_req(KIND_SPLAT, Scale + half, 2 * Scale + half, 3 * Scale + half,
                          0, 128, 255, 0, 0, 0));
    send_request(make_req(KIND_READ, 0, 0, 0, 0, 0, 0, 2, 3, 4));
    send_request(make_req(KIND_SPLAT, 2 * Scale + half, 2 * Scale + half,
                          2 * Scale + 20 * Scale / 256, 255, 255, 255, 0, 0, 0));
    send_request(make_req(KIND_SPLAT, 4 * Scale + half, 4 * Scale + half,
                          4 * Scale + 21 * Scale / 256, 255, 255, 255, 0, 0, 0));
    send_request(make_req(KIND_READ, 0, 0, 0, 0, 0, 0, 3, 3, 3));
    send_request(make_req(KIND_READ, 0, 0, 0, 0, 0, 0, 5, 5, 5));
    send_request(make_req(KIND_NOP, 8191, -8192, 0, 255, 255, 255, 7, 7, 7));
    send_request(make_req(KIND_READ, 0, 0, 0, 0, 0, 0, 1, 2, 3));
    send_request(make_req(KIND_CLEAR, -1, -1, -1, 255, 255, 255, 7, 7, 7));
    send_request(make_req(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_req(KIND_READ, 0, 0, 0, 0, 0, 0, 7, 7, 7));
    wait_reads_drained();
  endtask

  task automatic test_random_no_idle();
    run_random_phase(320, 0, 0);
  endtask

  task automatic test_random_sender_idle();
    run_random_phase(310, 64, 0);
  endtask

  task automatic test_random_receiver_stall();
    run_random_phase(310, 0, 64);
  endtask

  task automatic test_random_both_idle();
    run_random_phase(310, 10, 10);
  endtask

  initial begin
    rst_ni          = 1'b0;
    req_if.valid    = 1'b0;
    req_if.kind     = KIND_NOP;
    req_if.pos_x    = '0;
    req_if.pos_y    = '0;
    req_if.pos_z    = '0;
    req_if.red_in   = '0;
    req_if.green_in = '0;
    req_if.blue_in  = '0;
    req_if.read_x   = '0;
    req_if.read_y   = '0;
    req_if.read_z   = '0;
    rsp_if.ready    = 1'b0;
    src_idle_pct    = 0;
    snk_stall_pct   = 0;
    error_count     = 0;
    cycle_count     = 0;
    n_clear         = 0;
    n_splat         = 0;
    n_read          = 0;
    n_nop           = 0;
    n_checked       = 0;
    clear_store();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_random_no_idle();
    test_random_sender_idle();
    test_random_receiver_stall();
    test_random_both_idle();

    while (read_colors_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    $display("Sent %0d splats, %0d reads, %0d clears and %0d no-ops under free, sender-idle,",
             n_splat, n_read, n_clear, n_nop);
    $display("receiver-stall and mixed pacing; %0d voxel reads compared in %0d cycles",
             n_checked, cycle_count);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/vtsm_pkg.sv
hdl/vtsm_if.sv
hdl/voxel_trilinear_splat_max_unit.sv
tb/voxel_trilinear_splat_max_unit_tb.sv
